@@ rtl/dcd_pkg.sv @@
package dcd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIGITS_DEFAULT = 16;
    localparam int WORD_BITS_DEFAULT  = 32;

    // Fixed field widths
    localparam int STREAM_W   = 32;
    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 33;
    localparam int CFG_DIGITS = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int DIGIT_W    = 4;

    // Digit width limits and width of digits after the configured ones
    localparam logic [2:0] WIDTH_MIN  = 3'd2;
    localparam logic [2:0] WIDTH_MAX  = 3'd4;
    localparam logic [2:0] TAIL_WIDTH = 3'd2;

    // Saturation ceiling of the sums and weights
    localparam logic [SUM_W-1:0] SUM_CAP = {1'b1, {(SUM_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIGIT_WIDTH_0 = 2'd0,
        REG_DIGIT_WIDTH_1 = 2'd1,
        REG_DIGIT_WIDTH_2 = 2'd2,
        REG_DIGIT_WIDTH_3 = 2'd3
    } reg_index_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Result of one fetch step out of the word shift register
    typedef struct packed {
        logic               complete;
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] mask;
        logic [2:0]         pend_bits;
        logic [1:0]         pend_cnt;
        logic [2:0]         take;
    } fetch_t;

    // Running codeword accumulation
    typedef struct packed {
        logic [SUM_W-1:0] partial;
        logic [SUM_W-1:0] weight;
        logic [SUM_W-1:0] prefix;
        logic             ovf;
    } cw_t;

    // Clamp a configured width into the legal range
    function automatic logic [2:0] clamp_width(input logic [2:0] w);
        logic [2:0] r;
        r = w;
        if (w < WIDTH_MIN)
            r = WIDTH_MIN;
        else if (w > WIDTH_MAX)
            r = WIDTH_MAX;
        return r;
    endfunction

    // Mask of the n low bits, n up to four
    function automatic logic [DIGIT_W-1:0] low_mask(input logic [2:0] n);
        logic [DIGIT_W:0] m;
        m = (5'd1 << n) - 5'd1;
        return m[DIGIT_W-1:0];
    endfunction

endpackage

@@ rtl/delimiter_code_decoder_core.sv @@
// Channel  | Direction | tdata                        | tuser         | tlast
// s_*      | in        | [31:0] stream_word           | -             | -
// m_*      | out       | [31:0] decoded_value         | [0] too_large | last_of_word
// cfg_*    | in        | cfg_index selects digit_width_0..3, cfg_data [2:0]
//
// One request per word: s_tready is high only while idle. After acceptance
// the sequencer resolves one digit (or the leftover fragment) per cycle
// through the shared digit datapath unless an output stall holds it, then
// flushes the last result before it returns to idle; wider digits need
// fewer steps per word. Each result is held until the next delimiter or
// the end of the word so last_of_word is known; a delimiter or flush
// waits while the output register is full and m_tready is low.
// Reset (rst_n, async) clears the codeword state and sets widths to 2.
module delimiter_code_decoder_core #(
    parameter int MAX_DIGITS = dcd_pkg::MAX_DIGITS_DEFAULT,
    parameter int WORD_BITS  = dcd_pkg::WORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // stream_word
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dcd_pkg::STREAM_W-1:0]  s_tdata,
    // decoded_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dcd_pkg::VALUE_W-1:0]   m_tdata,
    // too_large
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_W  = $clog2(MAX_DIGITS + 1);
    localparam int LEFT_W = $clog2(WORD_BITS + 1);

    // Registers
    dcd_pkg::state_t       state_reg, state_next;
    logic [2:0]            width_reg [dcd_pkg::CFG_DIGITS];
    logic [WORD_BITS-1:0]  shift_reg, shift_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [2:0]            pend_bits_reg, pend_bits_next;
    logic [1:0]            pend_cnt_reg, pend_cnt_next;
    dcd_pkg::cw_t          cw_reg, cw_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  held_valid_reg, held_valid_next;
    logic [dcd_pkg::VALUE_W-1:0] held_value_reg, held_value_next;
    logic                  held_big_reg, held_big_next;
    logic                  out_valid_reg, out_valid_next;
    logic [dcd_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                  out_big_reg, out_big_next;
    logic                  out_last_reg, out_last_next;

    // Datapath wires
    logic [2:0]            cur_width;
    dcd_pkg::fetch_t       fetch;
    logic [WORD_BITS-1:0]  fetch_shift;
    logic [LEFT_W-1:0]     fetch_left;
    logic                  is_delim;
    dcd_pkg::cw_t          unit_cw;
    logic [POS_W-1:0]      unit_pos;
    logic [dcd_pkg::VALUE_W-1:0] unit_value;
    logic                  unit_big;
    logic                  out_free;
    logic                  accept;

    // Width of the digit at the current position
    always_comb
    begin
        if (pos_reg < POS_W'(dcd_pkg::CFG_DIGITS))
            cur_width = dcd_pkg::clamp_width(width_reg[pos_reg[1:0]]);
        else
            cur_width = dcd_pkg::TAIL_WIDTH;
    end

    dcd_digit_fetch #(
        .WORD_BITS (WORD_BITS),
        .LEFT_W    (LEFT_W)
    ) u_fetch (
        .shift_word (shift_reg),
        .bits_left  (left_reg),
        .pend_bits  (pend_bits_reg),
        .pend_cnt   (pend_cnt_reg),
        .width      (cur_width),
        .fetch      (fetch),
        .shift_next (fetch_shift),
        .left_next  (fetch_left)
    );

    dcd_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS),
        .POS_W      (POS_W)
    ) u_unit (
        .digit     (fetch.digit),
        .mask      (fetch.mask),
        .cw        (cw_reg),
        .pos       (pos_reg),
        .is_delim  (is_delim),
        .cw_next   (unit_cw),
        .pos_next  (unit_pos),
        .value     (unit_value),
        .too_large (unit_big)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == dcd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        shift_next      = shift_reg;
        left_next       = left_reg;
        pend_bits_next  = pend_bits_reg;
        pend_cnt_next   = pend_cnt_reg;
        cw_next         = cw_reg;
        pos_next        = pos_reg;
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        held_big_next   = held_big_reg;
        out_value_next  = out_value_reg;
        out_big_next    = out_big_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        unique case (state_reg)
            dcd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    shift_next = WORD_BITS'(s_tdata);
                    left_next  = LEFT_W'(WORD_BITS);
                    state_next = dcd_pkg::ST_RUN;
                end
            end
            dcd_pkg::ST_RUN:
            begin
                if (left_reg == '0)
                begin
                    // End of word: release the held result as the last one
                    if (!held_valid_reg)
                        state_next = dcd_pkg::ST_IDLE;
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = held_value_reg;
                        out_big_next    = held_big_reg;
                        out_last_next   = 1'b1;
                        held_valid_next = 1'b0;
                        state_next      = dcd_pkg::ST_IDLE;
                    end
                end
                else if (!(fetch.complete && is_delim && held_valid_reg && !out_free))
                begin
                    shift_next     = fetch_shift;
                    left_next      = fetch_left;
                    pend_bits_next = fetch.pend_bits;
                    pend_cnt_next  = fetch.pend_cnt;
                    if (fetch.complete)
                    begin
                        if (is_delim)
                        begin
                            // Older result is not the last of the word
                            if (held_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = held_value_reg;
                                out_big_next   = held_big_reg;
                                out_last_next  = 1'b0;
                            end
                            held_valid_next = 1'b1;
                            held_value_next = unit_value;
                            held_big_next   = unit_big;
                            // Restart the codeword
                            cw_next.partial = '0;
                            cw_next.weight  = dcd_pkg::SUM_W'(1);
                            cw_next.prefix  = '0;
                            cw_next.ovf     = 1'b0;
                            pos_next        = '0;
                        end
                        else
                        begin
                            cw_next  = unit_cw;
                            pos_next = unit_pos;
                        end
                    end
                end
            end
            default:
            begin
                state_next = dcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and codeword state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dcd_pkg::ST_IDLE;
            left_reg       <= '0;
            pend_bits_reg  <= '0;
            pend_cnt_reg   <= '0;
            cw_reg.partial <= '0;
            cw_reg.weight  <= dcd_pkg::SUM_W'(1);
            cw_reg.prefix  <= '0;
            cw_reg.ovf     <= 1'b0;
            pos_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            left_reg       <= left_next;
            pend_bits_reg  <= pend_bits_next;
            pend_cnt_reg   <= pend_cnt_next;
            cw_reg         <= cw_next;
            pos_reg        <= pos_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Digit width registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcd_pkg::CFG_DIGITS; i++)
                width_reg[i] <= dcd_pkg::WIDTH_MIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcd_pkg::REG_DIGIT_WIDTH_0: width_reg[0] <= cfg_data;
                dcd_pkg::REG_DIGIT_WIDTH_1: width_reg[1] <= cfg_data;
                dcd_pkg::REG_DIGIT_WIDTH_2: width_reg[2] <= cfg_data;
                dcd_pkg::REG_DIGIT_WIDTH_3: width_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg      <= shift_next;
        held_value_reg <= held_value_next;
        held_big_reg   <= held_big_next;
        out_value_reg  <= out_value_next;
        out_big_reg    <= out_big_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_big_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/dcd_digit_fetch.sv @@
module dcd_digit_fetch #(
    parameter int WORD_BITS = dcd_pkg::WORD_BITS_DEFAULT,
    parameter int LEFT_W    = $clog2(WORD_BITS + 1)
) (
    input  logic [WORD_BITS-1:0] shift_word,
    input  logic [LEFT_W-1:0]    bits_left,
    input  logic [2:0]           pend_bits,
    input  logic [1:0]           pend_cnt,
    input  logic [2:0]           width,
    output dcd_pkg::fetch_t      fetch,
    output logic [WORD_BITS-1:0] shift_next,
    output logic [LEFT_W-1:0]    left_next
);

    logic [2:0]               need;
    logic                     complete;
    logic [2:0]               take;
    logic [dcd_pkg::DIGIT_W-1:0] raw;
    logic [6:0]               merged;

    always_comb
    begin
        // Bits still missing for the current digit; a stale fragment that is
        // already as long as the width closes with one more bit
        if ({1'b0, pend_cnt} >= width)
            need = 3'd1;
        else
            need = width - {1'b0, pend_cnt};

        complete = (bits_left >= LEFT_W'(need));
        take     = complete ? need : bits_left[2:0];

        // Append the new bits above the pending fragment
        raw    = shift_word[dcd_pkg::DIGIT_W-1:0] & dcd_pkg::low_mask(take);
        merged = (7'(raw) << pend_cnt) | 7'(pend_bits);

        fetch.complete  = complete;
        fetch.mask      = dcd_pkg::low_mask(width);
        fetch.digit     = merged[dcd_pkg::DIGIT_W-1:0] & fetch.mask;
        fetch.pend_bits = complete ? 3'd0 : merged[2:0];
        fetch.pend_cnt  = complete ? 2'd0 : pend_cnt + take[1:0];
        fetch.take      = take;

        shift_next = shift_word >> take;
        left_next  = bits_left - LEFT_W'(take);
    end

endmodule

@@ rtl/dcd_digit_unit.sv @@
module dcd_digit_unit #(
    parameter int MAX_DIGITS = dcd_pkg::MAX_DIGITS_DEFAULT,
    parameter int POS_W      = $clog2(MAX_DIGITS + 1)
) (
    input  logic [dcd_pkg::DIGIT_W-1:0] digit,
    input  logic [dcd_pkg::DIGIT_W-1:0] mask,
    input  dcd_pkg::cw_t                cw,
    input  logic [POS_W-1:0]            pos,
    output logic                        is_delim,
    output dcd_pkg::cw_t                cw_next,
    output logic [POS_W-1:0]            pos_next,
    output logic [dcd_pkg::VALUE_W-1:0] value,
    output logic                        too_large
);

    localparam int PROD_W = dcd_pkg::SUM_W + dcd_pkg::DIGIT_W;

    logic [PROD_W-1:0]          prod;
    logic [PROD_W:0]            sum;
    logic [PROD_W-1:0]          wprod;
    logic [dcd_pkg::SUM_W:0]    pre;
    logic [dcd_pkg::SUM_W:0]    total;

    always_comb
    begin
        is_delim = (digit == mask);

        // Accumulate digit times weight, saturating at the ceiling
        prod = PROD_W'(digit) * PROD_W'(cw.weight);
        sum  = (PROD_W+1)'(cw.partial) + (PROD_W+1)'(prod);
        cw_next.partial = (sum > (PROD_W+1)'(dcd_pkg::SUM_CAP)) ?
                          dcd_pkg::SUM_CAP : sum[dcd_pkg::SUM_W-1:0];

        // Offset grows by the weight of each non-delimiter digit
        pre = (dcd_pkg::SUM_W+1)'(cw.prefix) + (dcd_pkg::SUM_W+1)'(cw.weight);
        cw_next.prefix = (pre > (dcd_pkg::SUM_W+1)'(dcd_pkg::SUM_CAP)) ?
                         dcd_pkg::SUM_CAP : pre[dcd_pkg::SUM_W-1:0];

        // Next place weight is this weight times the digit radix minus one
        wprod = PROD_W'(cw.weight) * PROD_W'(mask);
        cw_next.weight = (wprod > PROD_W'(dcd_pkg::SUM_CAP)) ?
                         dcd_pkg::SUM_CAP : wprod[dcd_pkg::SUM_W-1:0];

        // Digit count bound
        cw_next.ovf = cw.ovf || ((POS_W+1)'(pos) + (POS_W+1)'(1) >=
                                 (POS_W+1)'(MAX_DIGITS));
        pos_next = (pos < POS_W'(MAX_DIGITS)) ? pos + POS_W'(1) : pos;

        // Value of a codeword closed by a delimiter here
        total = (dcd_pkg::SUM_W+1)'(cw.partial) + (dcd_pkg::SUM_W+1)'(cw.prefix);
        too_large = cw.ovf || (total[dcd_pkg::SUM_W:dcd_pkg::VALUE_W] != 2'd0);
        value = too_large ? {dcd_pkg::VALUE_W{1'b1}} : total[dcd_pkg::VALUE_W-1:0];
    end

endmodule
